### sv/param_record_crc_validator_core_assert.svh
// assertion macros for the parameter record validator
`ifndef PARAM_RECORD_CRC_VALIDATOR_CORE_ASSERT_SVH
`define PARAM_RECORD_CRC_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PCV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcv assertion failed");

// next-cycle implication
`define PCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcv assertion failed");

`endif

### sv/pcv_pkg.sv
// types, constants and crc functions of the parameter record validator
package pcv_pkg;

   localparam logic [15:0] REC_MAGIC = 16'hE071;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_TOP   = 16'h8000;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_TAG  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PARAM_COUNT = 1'b1;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_RESET = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_ID       = 3'd1,
      ST_RANGE        = 3'd2,
      ST_READ         = 3'd3,
      ST_MAGIC        = 3'd4,
      ST_CRC          = 3'd5,
      ST_STORED_RANGE = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] dflt;
   } desc_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] param_id;
      logic [15:0] data_value;
      logic [15:0] stored_magic;
      logic [15:0] stored_crc;
      logic        read_failed;
      logic [15:0] min_value;
      logic [15:0] max_value;
      logic [15:0] default_value;
   } req_word_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [15:0] out_magic;
      logic [15:0] out_crc;
      logic        write_record;
      logic [15:0] record_address;
      status_type  status;
   } rsp_word_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // little-endian: low byte first
   function automatic logic [15:0] crc_word(input logic [15:0] crc_in, input logic [15:0] w);
      return crc_byte(crc_byte(crc_in, w[7:0]), w[15:8]);
   endfunction

endpackage

### sv/pcv_chan_if.sv
// valid/ready channel carrying one word of a given type
interface pcv_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/pcv_desc_ram.sv
// descriptor table ram, one write port and one registered read port
module pcv_desc_ram
   import pcv_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  desc_type         wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output desc_type         rd_data
);

   desc_type mem [DEPTH];
   desc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/param_record_crc_validator_core.sv
// top level of the parameter record validator
// Takes one request word per clock when the response side does not stall and returns exactly
// one response word for each, in order. The three register stages are the descriptor ram read
// with the crc over magic and device tag, then the crc over the id bytes with value selection
// and range compare, then the crc over the value bytes and the status decision into the output
// register. A stall on the response side holds the whole pipeline. A descriptor load is visible
// to a request accepted in the next clock. Reading the descriptor of an id that was never loaded
// gives undefined min, max and default.
`include "param_record_crc_validator_core_assert.svh"

module param_record_crc_validator_core
   import pcv_pkg::*;
#(
   parameter int MAX_PARAMS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   pcv_chan_if.sink              req_bus,
   pcv_chan_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam logic [16:0] ID_LIMIT = 17'(MAX_PARAMS);

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] id;
      logic [15:0] val;
      logic [15:0] smagic;
      logic [15:0] scrc;
      logic        rfail;
      logic        id_ok;
      logic [15:0] crc;
   } s1_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] val;
      logic [15:0] dflt;
      logic [15:0] addr;
      logic        magic_ok;
      logic [15:0] scrc;
      logic        rfail;
      logic        id_ok;
      logic        value_ok;
      logic [15:0] crc;
   } s2_type;

   logic [15:0]  device_tag_ff;
   logic [6:0]   param_count_ff;

   req_word_type req_w;
   logic         advance;
   logic         accept;
   logic         id_below_max;
   logic         id_below_cnt;
   logic         load_we;
   desc_type     load_desc;
   desc_type     rd_desc;

   logic         s1_valid_ff;
   s1_type       s1_in;
   s1_type       s1_ff;
   logic         s2_valid_ff;
   s2_type       s2_in;
   s2_type       s2_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_in;
   rsp_word_type rsp_word_ff;

   logic [15:0]  s2_v;
   logic [15:0]  s3_crc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_tag_ff  <= '0;
         param_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEVICE_TAG:  device_tag_ff  <= csr_wdata;
            REG_PARAM_COUNT: param_count_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // stage 0: handshake, id checks, ram access
   assign req_w   = req_bus.data;
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign accept  = req_bus.valid && advance;
   assign req_bus.ready = advance;

   assign id_below_max = {1'b0, req_w.param_id} < ID_LIMIT;
   assign id_below_cnt = req_w.param_id < {9'd0, param_count_ff};
   assign load_we      = accept && (req_w.cmd == CMD_LOAD) && id_below_max;
   assign load_desc    = '{lo: req_w.min_value, hi: req_w.max_value, dflt: req_w.default_value};

   pcv_desc_ram #(
      .DEPTH (MAX_PARAMS),
      .IDX_W (IDX_W)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_idx  (req_w.param_id[IDX_W-1:0]),
      .wr_data (load_desc),
      .rd_en   (advance),
      .rd_idx  (req_w.param_id[IDX_W-1:0]),
      .rd_data (rd_desc)
   );

   always_comb begin
      s1_in.cmd    = req_w.cmd;
      s1_in.id     = req_w.param_id;
      s1_in.val    = req_w.data_value;
      s1_in.smagic = req_w.stored_magic;
      s1_in.scrc   = req_w.stored_crc;
      s1_in.rfail  = req_w.read_failed;
      s1_in.id_ok  = (req_w.cmd == CMD_LOAD) ? id_below_max : (id_below_max && id_below_cnt);
      s1_in.crc    = crc_word(crc_word(CRC_INIT, REC_MAGIC), device_tag_ff);
   end

   // stage 1 to 2: value select, range compare, crc over id
   assign s2_v = (s1_ff.cmd == CMD_RESET) ? rd_desc.dflt : s1_ff.val;

   always_comb begin
      s2_in.cmd      = s1_ff.cmd;
      s2_in.val      = s2_v;
      s2_in.dflt     = rd_desc.dflt;
      s2_in.addr     = 16'({s1_ff.id, 2'b00}) + 16'({s1_ff.id, 1'b0});
      s2_in.magic_ok = s1_ff.smagic == REC_MAGIC;
      s2_in.scrc     = s1_ff.scrc;
      s2_in.rfail    = s1_ff.rfail;
      s2_in.id_ok    = s1_ff.id_ok;
      s2_in.value_ok = (s2_v >= rd_desc.lo) && (s2_v <= rd_desc.hi);
      s2_in.crc      = crc_word(s1_ff.crc, s1_ff.id);
   end

   // stage 2 to output: crc over value, status
   assign s3_crc = crc_word(s2_ff.crc, s2_ff.val);

   always_comb begin
      rsp_in = '{result_value: '0, out_magic: '0, out_crc: '0, write_record: 1'b0,
                 record_address: '0, status: ST_OK};
      if (!s2_ff.id_ok) begin
         rsp_in.status = ST_BAD_ID;
      end else if (s2_ff.cmd == CMD_LOAD) begin
         rsp_in.status = ST_OK;
      end else if (s2_ff.cmd == CMD_GET) begin
         rsp_in.record_address = s2_ff.addr;
         rsp_in.result_value   = s2_ff.dflt;
         if (s2_ff.rfail) begin
            rsp_in.status = ST_READ;
         end else if (!s2_ff.magic_ok) begin
            rsp_in.status = ST_MAGIC;
         end else if (s2_ff.scrc != s3_crc) begin
            rsp_in.status = ST_CRC;
         end else if (!s2_ff.value_ok) begin
            rsp_in.status = ST_STORED_RANGE;
         end else begin
            rsp_in.result_value = s2_ff.val;
         end
      end else begin
         rsp_in.record_address = s2_ff.addr;
         rsp_in.result_value   = s2_ff.val;
         if (!s2_ff.value_ok) begin
            rsp_in.status = ST_RANGE;
         end else begin
            rsp_in.out_magic    = REC_MAGIC;
            rsp_in.out_crc      = s3_crc;
            rsp_in.write_record = 1'b1;
         end
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_word_ff;

   `PCV_ASSERT_NOW(a_write_is_ok, clock, reset, rsp_valid_ff && rsp_word_ff.write_record, (rsp_word_ff.status == ST_OK) && (rsp_word_ff.out_magic == REC_MAGIC))
   `PCV_ASSERT_NOW(a_bad_id_zero, clock, reset, rsp_valid_ff && (rsp_word_ff.status == ST_BAD_ID), (rsp_word_ff.record_address == '0) && (rsp_word_ff.result_value == '0) && !rsp_word_ff.write_record)
   `PCV_ASSERT_NEXT(a_s2_reaches_out, clock, reset, s2_valid_ff && advance, rsp_valid_ff)
   `PCV_ASSERT_NEXT(a_stall_holds_s1, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_ff))

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// testbench of the parameter record validator: directed and random words checked against a predictor
module tb
   import pcv_pkg::*;
();

   localparam int TABLE_DEPTH  = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_WORDS  = 460;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pcv_chan_if #(.word_type(req_word_type)) req_bus ();
   pcv_chan_if #(.word_type(rsp_word_type)) rsp_bus ();

   param_record_crc_validator_core #(.MAX_PARAMS(TABLE_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   desc_type     desc_shadow [TABLE_DEPTH];
   bit           desc_loaded [TABLE_DEPTH];
   logic [15:0]  tag_shadow;
   logic [6:0]   count_shadow;
   rsp_word_type awaited_rsp [$];
   rsp_word_type got_word;
   rsp_word_type want_word;

   int idle_pct       = 31;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bitwise over the eight record bytes, low byte of each field first
   function automatic logic [15:0] record_crc(input logic [15:0] magic, input logic [15:0] tag,
                                              input logic [15:0] id, input logic [15:0] val);
      logic [63:0] msg;
      logic [15:0] c;
      msg = {magic[7:0], magic[15:8], tag[7:0], tag[15:8], id[7:0], id[15:8], val[7:0], val[15:8]};
      c = CRC_INIT;
      for (int i = 63; i >= 0; i--) begin
         if (c[15] ^ msg[i]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic bit id_in_use(input logic [15:0] id);
      return (id < count_shadow) && (id < TABLE_DEPTH);
   endfunction

   function automatic rsp_word_type predict_outcome(input req_word_type w);
      rsp_word_type r;
      desc_type     d;
      logic [15:0]  v;
      r = '0;
      r.status = ST_OK;
      if (w.cmd == CMD_LOAD) begin
         if (w.param_id < TABLE_DEPTH) begin
            desc_shadow[w.param_id[5:0]] = '{lo: w.min_value, hi: w.max_value, dflt: w.default_value};
            desc_loaded[w.param_id[5:0]] = 1'b1;
         end else begin
            r.status = ST_BAD_ID;
         end
      end else if (!id_in_use(w.param_id)) begin
         r.status = ST_BAD_ID;
      end else begin
         d = desc_shadow[w.param_id[5:0]];
         r.record_address = w.param_id * 16'd6;
         if (w.cmd == CMD_GET) begin
            r.result_value = d.dflt;
            if (w.read_failed) begin
               r.status = ST_READ;
            end else if (w.stored_magic != REC_MAGIC) begin
               r.status = ST_MAGIC;
            end else if (w.stored_crc != record_crc(w.stored_magic, tag_shadow, w.param_id,
                                                    w.data_value)) begin
               r.status = ST_CRC;
            end else if (w.data_value < d.lo || w.data_value > d.hi) begin
               r.status = ST_STORED_RANGE;
            end else begin
               r.result_value = w.data_value;
            end
         end else begin
            v = (w.cmd == CMD_RESET) ? d.dflt : w.data_value;
            r.result_value = v;
            if (v < d.lo || v > d.hi) begin
               r.status = ST_RANGE;
            end else begin
               r.out_magic    = REC_MAGIC;
               r.out_crc      = record_crc(REC_MAGIC, tag_shadow, w.param_id, v);
               r.write_record = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < 40) begin
         $display("mismatch in %s: got %h, expected %h", what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic send_word(input req_word_type w);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.data  <= w;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      awaited_rsp.push_back(predict_outcome(w));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] tag_value, input logic [6:0] count_value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= REG_DEVICE_TAG;
      csr_wdata <= tag_value;
      @(posedge clock);
      csr_index <= REG_PARAM_COUNT;
      csr_wdata <= {9'd0, count_value};
      @(posedge clock);
      csr_we <= 1'b0;
      tag_shadow   = tag_value;
      count_shadow = count_value;
      @(posedge clock);
   endtask

   function automatic req_word_type make_req(input cmd_type cmd, input logic [15:0] id,
                                             input logic [15:0] val, input logic [15:0] magic,
                                             input logic [15:0] crc, input logic rfail,
                                             input logic [15:0] lo, input logic [15:0] hi,
                                             input logic [15:0] dflt);
      req_word_type w;
      w.cmd           = cmd;
      w.param_id      = id;
      w.data_value    = val;
      w.stored_magic  = magic;
      w.stored_crc    = crc;
      w.read_failed   = rfail;
      w.min_value     = lo;
      w.max_value     = hi;
      w.default_value = dflt;
      return w;
   endfunction

   function automatic req_word_type good_get(input logic [15:0] id, input logic [15:0] val);
      return make_req(CMD_GET, id, val, REC_MAGIC, record_crc(REC_MAGIC, tag_shadow, id, val),
                      1'b0, '0, '0, '0);
   endfunction

   function automatic logic [15:0] value_between(input logic [15:0] lo, input logic [15:0] hi);
      return lo + 16'($urandom_range(int'(hi - lo)));
   endfunction

   function automatic logic [15:0] pick_id();
      int pick;
      int cnt;
      pick = $urandom_range(99);
      cnt  = count_shadow;
      if (pick < 80) begin
         return 16'($urandom_range(cnt > 0 ? cnt - 1 : 0));
      end else if (pick < 88) begin
         return 16'($urandom_range(cnt + 1));
      end else if (pick < 94) begin
         return 16'($urandom);
      end else begin
         return (pick < 97) ? 16'd63 : 16'd64;
      end
   endfunction

   function automatic req_word_type random_req();
      req_word_type w;
      desc_type     d;
      logic [15:0]  t;
      int           pick;
      w.param_id      = pick_id();
      w.data_value    = 16'($urandom);
      w.stored_magic  = 16'($urandom);
      w.stored_crc    = 16'($urandom);
      w.read_failed   = 1'($urandom);
      w.min_value     = 16'($urandom);
      w.max_value     = 16'($urandom);
      w.default_value = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 12) begin
         w.cmd = CMD_LOAD;
      end else if (pick < 62) begin
         w.cmd = CMD_GET;
      end else if (pick < 87) begin
         w.cmd = CMD_SET;
      end else begin
         w.cmd = CMD_RESET;
      end
      // a live id must have its descriptor before it is read
      if (w.cmd != CMD_LOAD && id_in_use(w.param_id) && !desc_loaded[w.param_id[5:0]]) begin
         w.cmd = CMD_LOAD;
      end
      if (w.cmd == CMD_LOAD) begin
         if ($urandom_range(1) == 0) begin
            w.max_value = w.min_value + 16'($urandom_range(20));
         end
         if (w.min_value > w.max_value && $urandom_range(99) < 85) begin
            t           = w.min_value;
            w.min_value = w.max_value;
            w.max_value = t;
         end
         if (w.min_value <= w.max_value && $urandom_range(99) < 80) begin
            w.default_value = value_between(w.min_value, w.max_value);
         end
      end else if (id_in_use(w.param_id)) begin
         d = desc_shadow[w.param_id[5:0]];
         if (d.lo <= d.hi && $urandom_range(99) < 78) begin
            w.data_value = value_between(d.lo, d.hi);
         end
         if (w.cmd == CMD_GET) begin
            w.read_failed  = 1'b0;
            w.stored_magic = REC_MAGIC;
            w.stored_crc   = record_crc(REC_MAGIC, tag_shadow, w.param_id, w.data_value);
            pick = $urandom_range(99);
            if (pick < 8) begin
               w.read_failed = 1'b1;
            end else if (pick < 16) begin
               w.stored_magic = 16'($urandom);
            end else if (pick < 24) begin
               w.stored_crc = w.stored_crc ^ (16'd1 << $urandom_range(15));
            end else if (pick < 28) begin
               w.stored_crc = 16'($urandom);
            end
         end
      end
      return w;
   endfunction

   task automatic test_reset_values();
      send_word(good_get(16'd0, 16'd0));
      send_word(make_req(CMD_SET, 16'd5, 16'd7, '0, '0, 1'b0, '0, '0, '0));
   endtask

   task automatic test_descriptor_loads();
      send_word(make_req(CMD_LOAD, 16'd0, '0, '0, '0, 1'b0, 16'h0000, 16'hFFFF, 16'h1234));
      send_word(make_req(CMD_LOAD, 16'd63, '0, '0, '0, 1'b0, 16'h0100, 16'h0200, 16'hFFFF));
      send_word(make_req(CMD_LOAD, 16'd1, '0, '0, '0, 1'b0, 16'h8000, 16'h8000, 16'h8000));
      send_word(make_req(CMD_LOAD, 16'd64, '0, '0, '0, 1'b0, 16'h0001, 16'h0002, 16'h0001));
      send_word(make_req(CMD_LOAD, 16'hFFFF, '0, '0, '0, 1'b0, 16'h0001, 16'h0002, 16'h0001));
   endtask

   task automatic test_get_checks();
      req_word_type w;
      set_registers(16'hFFFF, 7'd64);
      w = good_get(16'd0, 16'h0042);
      w.read_failed = 1'b1;
      send_word(w);
      w = good_get(16'd0, 16'h0042);
      w.stored_magic = 16'hE070;
      send_word(w);
      w = good_get(16'd63, 16'h0150);
      w.stored_crc = w.stored_crc ^ 16'h0001;
      send_word(w);
      send_word(good_get(16'd63, 16'h0050));
      send_word(good_get(16'd0, 16'hFFFF));
      send_word(good_get(16'd63, 16'h0200));
   endtask

   task automatic test_write_commands();
      send_word(make_req(CMD_SET, 16'd63, 16'h0100, '0, '0, 1'b0, '0, '0, '0));
      send_word(make_req(CMD_SET, 16'd63, 16'h00FF, '0, '0, 1'b0, '0, '0, '0));
      send_word(make_req(CMD_SET, 16'd63, 16'h0201, '0, '0, 1'b0, '0, '0, '0));
      send_word(make_req(CMD_RESET, 16'd63, 16'h0150, '0, '0, 1'b0, '0, '0, '0));
      send_word(make_req(CMD_RESET, 16'd1, '0, '0, '0, 1'b0, '0, '0, '0));
      send_word(make_req(CMD_SET, 16'd0, 16'h0000, '0, '0, 1'b0, '0, '0, '0));
   endtask

   task automatic test_bad_ids();
      set_registers(16'h0000, 7'd2);
      send_word(good_get(16'd63, 16'h0150));
      send_word(make_req(CMD_SET, 16'd2, 16'h0001, '0, '0, 1'b0, '0, '0, '0));
      send_word(good_get(16'd1, 16'h8000));
      send_word(make_req(CMD_RESET, 16'd64, '0, '0, '0, 1'b0, '0, '0, '0));
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_registers(16'($urandom), 7'd64);
            end
            1: begin
               set_registers(16'h0000, 7'($urandom_range(63, 1)));
            end
            2: begin
               set_registers(16'hFFFF, 7'd64);
            end
            default: begin
               set_registers(16'($urandom), 7'd1);
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            idle_pct = (phase == 2 && n < 300) ? 0 : 31;
            // hold the sender until the pipeline is empty
            if (n == PHASE_WORDS / 2) begin
               drain_results();
            end
            send_word(random_req());
         end
      end
      idle_pct = 31;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_bus.data.result_value, '0);
         end else begin
            want_word = awaited_rsp.pop_front();
            got_word  = rsp_bus.data;
            if (got_word.result_value !== want_word.result_value) begin
               report_mismatch("result_value", got_word.result_value, want_word.result_value);
            end
            if (got_word.out_magic !== want_word.out_magic) begin
               report_mismatch("out_magic", got_word.out_magic, want_word.out_magic);
            end
            if (got_word.out_crc !== want_word.out_crc) begin
               report_mismatch("out_crc", got_word.out_crc, want_word.out_crc);
            end
            if (got_word.write_record !== want_word.write_record) begin
               report_mismatch("write_record", 16'(got_word.write_record),
                               16'(want_word.write_record));
            end
            if (got_word.record_address !== want_word.record_address) begin
               report_mismatch("record_address", got_word.record_address,
                               want_word.record_address);
            end
            if (got_word.status !== want_word.status) begin
               report_mismatch("status", 16'(got_word.status), 16'(want_word.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** param_record_crc_validator_core: FAILED **");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      tag_shadow   = '0;
      count_shadow = '0;
      foreach (desc_loaded[i]) begin
         desc_loaded[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_descriptor_loads();
      test_get_checks();
      test_write_commands();
      test_bad_ids();
      test_random_traffic();
      drain_results();
      if (mismatch_count == 0) begin
         $display("** param_record_crc_validator_core: PASSED **");
      end else begin
         $display("** param_record_crc_validator_core: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/pcv_pkg.sv
sv/pcv_chan_if.sv
sv/pcv_desc_ram.sv
sv/param_record_crc_validator_core.sv
sim/tb.sv
